// File: hw/rtl/dhb_pkg.sv
// Shared types, widths and constants of the dual H-bridge command block.
`timescale 1ns / 1ps

package dhb_pkg;

  // Field widths
  localparam int CMD_W  = 16;              // signed command and request width
  localparam int LIM_W  = 15;              // command limit / magnitude width
  localparam int PER_W  = 16;              // PWM period and compare width
  localparam int DIVD_W = LIM_W + PER_W;   // magnitude * period product width
  localparam int DIV_STEPS = DIVD_W;       // one quotient bit per step

  // Configuration port
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int IDX_W  = ADDR_W - 2;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COMMAND_LIMIT = 3'd0;
  localparam logic [IDX_W-1:0] REG_PWM_PERIOD    = 3'd1;
  localparam logic [IDX_W-1:0] REG_LEFT_FWD      = 3'd2;
  localparam logic [IDX_W-1:0] REG_RIGHT_FWD     = 3'd3;
  localparam logic [IDX_W-1:0] REG_SWAP_SIDES    = 3'd4;

  // Register reset values
  localparam logic [LIM_W-1:0] LIMIT_RST  = 15'd1000;
  localparam logic [PER_W-1:0] PERIOD_RST = 16'd500;
  localparam logic             LEFT_FWD_RST  = 1'b1;
  localparam logic             RIGHT_FWD_RST = 1'b0;
  localparam logic             SWAP_RST      = 1'b0;

  // Item kinds
  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_STOP  = 1'b1;

  // Dead time between the safe and the final result, in clock cycles
  localparam int DEAD_TIME_CYCLES_DEF = 32001;

  typedef struct packed {
    logic [LIM_W-1:0] command_limit;
    logic [PER_W-1:0] pwm_period;
    logic             left_forward_in1_high;
    logic             right_forward_in1_high;
    logic             swap_sides;
  } cfg_t;

  typedef struct packed {
    logic                    chan_a_in1;
    logic                    chan_a_in2;
    logic                    chan_b_in1;
    logic                    chan_b_in2;
    logic [PER_W-1:0]        chan_a_compare;
    logic [PER_W-1:0]        chan_b_compare;
    logic signed [CMD_W-1:0] left_command_now;
    logic signed [CMD_W-1:0] right_command_now;
    logic                    last;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic ld_stop;
    logic ld_safe;
    logic mul;
    logic div_step;
    logic ld_final;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic stop;
    logic flip;
  } status_t;

endpackage

// File: hw/rtl/dhb_chan_if.sv
// Request and result channel interfaces of the dual H-bridge command block.
`timescale 1ns / 1ps

interface dhb_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   kind;
  logic signed [dhb_pkg::CMD_W-1:0]       left_request;
  logic signed [dhb_pkg::CMD_W-1:0]       right_request;

  modport source (output valid, kind, left_request, right_request, input ready);
  modport sink   (input valid, kind, left_request, right_request, output ready);
endinterface

interface dhb_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   chan_a_in1;
  logic                                   chan_a_in2;
  logic                                   chan_b_in1;
  logic                                   chan_b_in2;
  logic [dhb_pkg::PER_W-1:0]              chan_a_compare;
  logic [dhb_pkg::PER_W-1:0]              chan_b_compare;
  logic signed [dhb_pkg::CMD_W-1:0]       left_command_now;
  logic signed [dhb_pkg::CMD_W-1:0]       right_command_now;
  logic                                   last;

  modport source (output valid, chan_a_in1, chan_a_in2, chan_b_in1, chan_b_in2,
                  chan_a_compare, chan_b_compare, left_command_now,
                  right_command_now, last, input ready);
  modport sink   (input valid, chan_a_in1, chan_a_in2, chan_b_in1, chan_b_in2,
                  chan_a_compare, chan_b_compare, left_command_now,
                  right_command_now, last, output ready);
endinterface

// File: hw/rtl/dual_hbridge_pwm_command_core.sv
// Top level: saturate two motor commands and drive two H-bridge channels.
// A stop request shows its result in the cycle after acceptance; a drive
// request goes through the multiply, 31 divide steps and the FINAL state.
// A reversal shows the safe result in the cycle after acceptance; the final
// result follows the dead time, the multiply and the divide steps once the
// safe result is taken. One request at a time: no new request is accepted
// until the last result is taken. Reset (rst_n low, synchronous) clears pins,
// compares and stored commands to zero and loads the register defaults.
`timescale 1ns / 1ps

module dual_hbridge_pwm_command_core #(
  parameter int DEAD_TIME_CYCLES = dhb_pkg::DEAD_TIME_CYCLES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  dhb_in_if.sink                      in_ch,
  dhb_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dhb_pkg::ADDR_W-1:0]  paddr,
  input  logic [dhb_pkg::DATA_W-1:0]  pwdata,
  output logic [dhb_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);

  dhb_pkg::cfg_t    cfg;
  dhb_pkg::cmd_t    cmd;
  dhb_pkg::status_t status;
  dhb_pkg::res_t    res;
  logic             in_ready;
  logic             out_valid;

  dhb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dhb_ctrl #(
    .DEAD_TIME_CYCLES (DEAD_TIME_CYCLES)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dhb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .status           (status),
    .in_kind          (in_ch.kind),
    .in_left_request  (in_ch.left_request),
    .in_right_request (in_ch.right_request),
    .res              (res)
  );

  // Drive the channel ports
  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid;
  assign out_ch.chan_a_in1        = res.chan_a_in1;
  assign out_ch.chan_a_in2        = res.chan_a_in2;
  assign out_ch.chan_b_in1        = res.chan_b_in1;
  assign out_ch.chan_b_in2        = res.chan_b_in2;
  assign out_ch.chan_a_compare    = res.chan_a_compare;
  assign out_ch.chan_b_compare    = res.chan_b_compare;
  assign out_ch.left_command_now  = res.left_command_now;
  assign out_ch.right_command_now = res.right_command_now;
  assign out_ch.last              = res.last;

endmodule

// File: hw/rtl/dhb_regs.sv
// APB-style configuration registers of the dual H-bridge command block.
`timescale 1ns / 1ps

module dhb_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dhb_pkg::ADDR_W-1:0]   paddr,
  input  logic [dhb_pkg::DATA_W-1:0]   pwdata,
  output logic [dhb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output dhb_pkg::cfg_t                cfg
);

  dhb_pkg::cfg_t                 cfg_r;
  logic                          wr_en;
  logic [dhb_pkg::IDX_W-1:0]     idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[dhb_pkg::ADDR_W-1:2];
  assign cfg    = cfg_r;

  // Write the addressed register, keep only its low bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.command_limit          <= dhb_pkg::LIMIT_RST;
      cfg_r.pwm_period             <= dhb_pkg::PERIOD_RST;
      cfg_r.left_forward_in1_high  <= dhb_pkg::LEFT_FWD_RST;
      cfg_r.right_forward_in1_high <= dhb_pkg::RIGHT_FWD_RST;
      cfg_r.swap_sides             <= dhb_pkg::SWAP_RST;
    end else if (wr_en) begin
      unique case (idx)
        dhb_pkg::REG_COMMAND_LIMIT: cfg_r.command_limit <= pwdata[dhb_pkg::LIM_W-1:0];
        dhb_pkg::REG_PWM_PERIOD:    cfg_r.pwm_period    <= pwdata[dhb_pkg::PER_W-1:0];
        dhb_pkg::REG_LEFT_FWD:      cfg_r.left_forward_in1_high  <= pwdata[0];
        dhb_pkg::REG_RIGHT_FWD:     cfg_r.right_forward_in1_high <= pwdata[0];
        dhb_pkg::REG_SWAP_SIDES:    cfg_r.swap_sides    <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      dhb_pkg::REG_COMMAND_LIMIT: prdata = dhb_pkg::DATA_W'(cfg_r.command_limit);
      dhb_pkg::REG_PWM_PERIOD:    prdata = dhb_pkg::DATA_W'(cfg_r.pwm_period);
      dhb_pkg::REG_LEFT_FWD:      prdata = dhb_pkg::DATA_W'(cfg_r.left_forward_in1_high);
      dhb_pkg::REG_RIGHT_FWD:     prdata = dhb_pkg::DATA_W'(cfg_r.right_forward_in1_high);
      dhb_pkg::REG_SWAP_SIDES:    prdata = dhb_pkg::DATA_W'(cfg_r.swap_sides);
      default:                    prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/dhb_div.sv
// Serial restoring divider: one quotient bit per step, compare value result.
`timescale 1ns / 1ps

module dhb_div (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [dhb_pkg::DIVD_W-1:0]    dividend,
  input  logic [dhb_pkg::LIM_W-1:0]     divisor,
  output logic [dhb_pkg::PER_W-1:0]     quot_nxt
);

  // Quotient bits shift in at the bottom as dividend bits leave the top
  logic [dhb_pkg::DIVD_W-1:0]  q_r;
  logic [dhb_pkg::DIVD_W-1:0]  q_nxt;
  logic [dhb_pkg::LIM_W-1:0]   rem_r;
  logic [dhb_pkg::LIM_W-1:0]   rem_nxt;
  logic [dhb_pkg::LIM_W:0]     trial;
  logic [dhb_pkg::LIM_W:0]     diff;
  logic                        ge;

  always_comb begin
    trial    = {rem_r, q_r[dhb_pkg::DIVD_W-1]};
    diff     = trial - {1'b0, divisor};
    ge       = trial >= {1'b0, divisor};
    rem_nxt  = ge ? diff[dhb_pkg::LIM_W-1:0] : trial[dhb_pkg::LIM_W-1:0];
    q_nxt    = {q_r[dhb_pkg::DIVD_W-2:0], ge};
    quot_nxt = q_nxt[dhb_pkg::PER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

// File: hw/rtl/dhb_dp.sv
// Datapath: saturation, reversal check, duty scaling and the result register.
`timescale 1ns / 1ps

module dhb_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dhb_pkg::cfg_t                     cfg,
  input  dhb_pkg::cmd_t                     cmd,
  output dhb_pkg::status_t                  status,
  input  logic                              in_kind,
  input  logic signed [dhb_pkg::CMD_W-1:0]  in_left_request,
  input  logic signed [dhb_pkg::CMD_W-1:0]  in_right_request,
  output dhb_pkg::res_t                     res
);

  function automatic logic signed [dhb_pkg::CMD_W-1:0] sat_cmd(
    input logic signed [dhb_pkg::CMD_W-1:0] v,
    input logic [dhb_pkg::LIM_W-1:0]        lim
  );
    logic signed [dhb_pkg::CMD_W:0] v_x;
    logic signed [dhb_pkg::CMD_W:0] l_x;
    logic signed [dhb_pkg::CMD_W:0] nl_x;
    logic signed [dhb_pkg::CMD_W:0] r_x;
    v_x  = {v[dhb_pkg::CMD_W-1], v};
    l_x  = {2'b00, lim};
    nl_x = -l_x;
    if (v_x > l_x)       r_x = l_x;
    else if (v_x < nl_x) r_x = nl_x;
    else                 r_x = v_x;
    return r_x[dhb_pkg::CMD_W-1:0];
  endfunction

  function automatic logic [dhb_pkg::LIM_W-1:0] mag_of(
    input logic signed [dhb_pkg::CMD_W-1:0] v
  );
    logic signed [dhb_pkg::CMD_W-1:0] n;
    n = -v;
    return v[dhb_pkg::CMD_W-1] ? n[dhb_pkg::LIM_W-1:0] : v[dhb_pkg::LIM_W-1:0];
  endfunction

  function automatic logic flips(
    input logic signed [dhb_pkg::CMD_W-1:0] prev,
    input logic signed [dhb_pkg::CMD_W-1:0] next
  );
    return (prev != '0) && (next != '0) &&
           (prev[dhb_pkg::CMD_W-1] != next[dhb_pkg::CMD_W-1]);
  endfunction

  // Direction pins {IN1, IN2}
  function automatic logic [1:0] side_pins(
    input logic signed [dhb_pkg::CMD_W-1:0] c,
    input logic                             fwd
  );
    if (c == '0)                   return 2'b00;
    else if (c[dhb_pkg::CMD_W-1])  return {~fwd, fwd};
    else                           return {fwd, ~fwd};
  endfunction

  logic [dhb_pkg::LIM_W-1:0]          lim_eff;
  logic signed [dhb_pkg::CMD_W-1:0]   left_sat;
  logic signed [dhb_pkg::CMD_W-1:0]   right_sat;
  logic                               lf;
  logic                               rf;
  logic signed [dhb_pkg::CMD_W-1:0]   left_sat_r;
  logic signed [dhb_pkg::CMD_W-1:0]   right_sat_r;
  logic [dhb_pkg::LIM_W-1:0]          left_mag_r;
  logic [dhb_pkg::LIM_W-1:0]          right_mag_r;
  logic [dhb_pkg::DIVD_W-1:0]         left_prod;
  logic [dhb_pkg::DIVD_W-1:0]         right_prod;
  logic [dhb_pkg::PER_W-1:0]          left_quot;
  logic [dhb_pkg::PER_W-1:0]          right_quot;
  logic [1:0]                         l_pins;
  logic [1:0]                         r_pins;
  dhb_pkg::res_t                      res_r;
  dhb_pkg::res_t                      res_nxt;

  // Saturate the request and check for a reversal against the stored commands
  always_comb begin
    lim_eff   = (cfg.command_limit == '0) ? dhb_pkg::LIM_W'(1) : cfg.command_limit;
    left_sat  = sat_cmd(in_left_request, lim_eff);
    right_sat = sat_cmd(in_right_request, lim_eff);
    lf        = flips(res_r.left_command_now, left_sat);
    rf        = flips(res_r.right_command_now, right_sat);
    status.stop = (in_kind == dhb_pkg::KIND_STOP);
    status.flip = lf || rf;
  end

  // Hold the saturated commands of the accepted request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      left_sat_r  <= left_sat;
      right_sat_r <= right_sat;
      left_mag_r  <= mag_of(left_sat);
      right_mag_r <= mag_of(right_sat);
    end
  end

  // Magnitude times period, registered into the dividers
  assign left_prod  = {{dhb_pkg::PER_W{1'b0}}, left_mag_r} *
                      {{dhb_pkg::LIM_W{1'b0}}, cfg.pwm_period};
  assign right_prod = {{dhb_pkg::PER_W{1'b0}}, right_mag_r} *
                      {{dhb_pkg::LIM_W{1'b0}}, cfg.pwm_period};

  dhb_div u_div_left (
    .clk      (clk),
    .load     (cmd.mul),
    .step     (cmd.div_step),
    .dividend (left_prod),
    .divisor  (lim_eff),
    .quot_nxt (left_quot)
  );

  dhb_div u_div_right (
    .clk      (clk),
    .load     (cmd.mul),
    .step     (cmd.div_step),
    .dividend (right_prod),
    .divisor  (lim_eff),
    .quot_nxt (right_quot)
  );

  // Build the next result; the result register also holds the driven levels
  always_comb begin
    l_pins  = side_pins(left_sat_r, cfg.left_forward_in1_high);
    r_pins  = side_pins(right_sat_r, cfg.right_forward_in1_high);
    res_nxt = res_r;
    if (cmd.ld_stop) begin
      res_nxt      = '0;
      res_nxt.last = 1'b1;
    end else if (cmd.ld_safe) begin
      // zero the reversing side's compare, keep pins and stored commands
      if ((lf && !cfg.swap_sides) || (rf && cfg.swap_sides)) res_nxt.chan_a_compare = '0;
      if ((lf && cfg.swap_sides) || (rf && !cfg.swap_sides)) res_nxt.chan_b_compare = '0;
      res_nxt.last = 1'b0;
    end else if (cmd.ld_final) begin
      if (cfg.swap_sides) begin
        {res_nxt.chan_a_in1, res_nxt.chan_a_in2} = r_pins;
        {res_nxt.chan_b_in1, res_nxt.chan_b_in2} = l_pins;
        res_nxt.chan_a_compare = right_quot;
        res_nxt.chan_b_compare = left_quot;
      end else begin
        {res_nxt.chan_a_in1, res_nxt.chan_a_in2} = l_pins;
        {res_nxt.chan_b_in1, res_nxt.chan_b_in2} = r_pins;
        res_nxt.chan_a_compare = left_quot;
        res_nxt.chan_b_compare = right_quot;
      end
      res_nxt.left_command_now  = left_sat_r;
      res_nxt.right_command_now = right_sat_r;
      res_nxt.last              = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

// File: hw/rtl/dhb_ctrl.sv
// Controller: sequences capture, safe result, dead time, divide and final result.
`timescale 1ns / 1ps

module dhb_ctrl #(
  parameter int DEAD_TIME_CYCLES = dhb_pkg::DEAD_TIME_CYCLES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dhb_pkg::status_t  status,
  output dhb_pkg::cmd_t     cmd
);

  localparam int DEAD_W = (DEAD_TIME_CYCLES > 1) ? $clog2(DEAD_TIME_CYCLES) : 1;
  localparam int DIVC_W = $clog2(dhb_pkg::DIV_STEPS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SAFE  = 3'd1;
  localparam logic [2:0] S_DEAD  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FINAL = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [DEAD_W-1:0] dead_cnt_r, dead_cnt_nxt;
  logic [DIVC_W-1:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt    = state_r;
    dead_cnt_nxt = dead_cnt_r;
    div_cnt_nxt  = div_cnt_r;
    cmd          = '0;
    in_ready     = 1'b0;
    out_valid    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (status.stop) begin
            cmd.ld_stop = 1'b1;
            state_nxt   = S_FINAL;
          end else if (status.flip) begin
            cmd.ld_safe = 1'b1;
            state_nxt   = S_SAFE;
          end else begin
            state_nxt   = S_MUL;
          end
        end
      end
      S_SAFE: begin
        out_valid = 1'b1;
        if (out_ready) begin
          dead_cnt_nxt = DEAD_W'(DEAD_TIME_CYCLES - 1);
          state_nxt    = S_DEAD;
        end
      end
      // wait out the dead time before driving the reversed direction
      S_DEAD: begin
        if (dead_cnt_r == '0) state_nxt = S_MUL;
        else                  dead_cnt_nxt = dead_cnt_r - 1'b1;
      end
      S_MUL: begin
        cmd.mul     = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt_r == DIVC_W'(dhb_pkg::DIV_STEPS - 1)) begin
          cmd.ld_final = 1'b1;
          state_nxt    = S_FINAL;
        end else begin
          div_cnt_nxt  = div_cnt_r + 1'b1;
        end
      end
      S_FINAL: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      dead_cnt_r <= '0;
      div_cnt_r  <= '0;
    end else begin
      state_r    <= state_nxt;
      dead_cnt_r <= dead_cnt_nxt;
      div_cnt_r  <= div_cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/dhb_checker.sv
// Port-level checks of the dual H-bridge command block and their bind.
`timescale 1ns / 1ps

module dhb_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              a_in1,
  input logic                              a_in2,
  input logic                              b_in1,
  input logic                              b_in2,
  input logic [dhb_pkg::PER_W-1:0]         a_cmp,
  input logic [dhb_pkg::PER_W-1:0]         b_cmp,
  input logic signed [dhb_pkg::CMD_W-1:0]  left_now,
  input logic signed [dhb_pkg::CMD_W-1:0]  right_now,
  input logic                              last
);

  // A stalled result holds its payload
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(a_in1) && $stable(a_in2) &&
      $stable(b_in1) && $stable(b_in2) && $stable(a_cmp) && $stable(b_cmp) &&
      $stable(left_now) && $stable(right_now) && $stable(last))
    else $error("result changed while stalled");

  // No new request while a result is pending
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request accepted while a result is pending");

  // The dead time separates a safe result from the next one
  a_dead_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !last |=> !out_valid)
    else $error("result shown right after a safe result");

  // Never drive both inputs of a bridge high
  a_no_shoot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(a_in1 && a_in2) && !(b_in1 && b_in2))
    else $error("both bridge inputs high");

endmodule

bind dual_hbridge_pwm_command_core dhb_checker u_dhb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .a_in1     (out_ch.chan_a_in1),
  .a_in2     (out_ch.chan_a_in2),
  .b_in1     (out_ch.chan_b_in1),
  .b_in2     (out_ch.chan_b_in2),
  .a_cmp     (out_ch.chan_a_compare),
  .b_cmp     (out_ch.chan_b_compare),
  .left_now  (out_ch.left_command_now),
  .right_now (out_ch.right_command_now),
  .last      (out_ch.last)
);

// File: dv/dual_hbridge_pwm_command_core_tb.sv
// Self-checking testbench for the dual H-bridge PWM command core.
`timescale 1ns / 1ps

module dual_hbridge_pwm_command_core_tb;
  import dhb_pkg::*;

  localparam int DEAD_CYCLES  = 40;        // shortened dead time keeps reversals cheap
  localparam int DRIVE_LAT    = 34;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 115;
  localparam int HOLD_CYCLES  = 2000;

  // Predicts pin, compare and stored-command results and checks them in order
  class hbridge_scoreboard;
    logic [LIM_W-1:0] limit_reg;
    logic [PER_W-1:0] period_reg;
    bit               left_fwd;
    bit               right_fwd;
    bit               swap;
    int               left_cmd;
    int               right_cmd;
    bit               a1, a2, b1, b2;
    int               cmp_a, cmp_b;
    res_t             expected_results[$];
    int               errors;
    int               requests;
    int               stops;
    int               safe_seen;
    int               results_checked;

    function new();
      limit_reg  = LIMIT_RST;
      period_reg = PERIOD_RST;
      left_fwd   = LEFT_FWD_RST;
      right_fwd  = RIGHT_FWD_RST;
      swap       = SWAP_RST;
      left_cmd   = 0;
      right_cmd  = 0;
      {a1, a2, b1, b2} = 4'b0000;
      cmp_a = 0;
      cmp_b = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_COMMAND_LIMIT: limit_reg = data[LIM_W-1:0];
        REG_PWM_PERIOD:    period_reg = data[PER_W-1:0];
        REG_LEFT_FWD:      left_fwd = data[0];
        REG_RIGHT_FWD:     right_fwd = data[0];
        REG_SWAP_SIDES:    swap = data[0];
        default: ;
      endcase
    endfunction

    function int clamp(int v, int lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
    endfunction

    function bit reverses(int prev, int next);
      return prev != 0 && next != 0 && ((prev < 0) != (next < 0));
    endfunction

    function void side_levels(int c, bit f, output bit p1, output bit p2);
      if (c == 0) begin
        p1 = 1'b0;
        p2 = 1'b0;
      end else if (c < 0) begin
        p1 = !f;
        p2 = f;
      end else begin
        p1 = f;
        p2 = !f;
      end
    endfunction

    function int duty_count(int c, int lim);
      longint mag;
      mag = (c < 0) ? -c : c;
      return int'((mag * longint'(period_reg)) / lim);
    endfunction

    function res_t snapshot(bit last_flag);
      res_t s;
      s.chan_a_in1        = a1;
      s.chan_a_in2        = a2;
      s.chan_b_in1        = b1;
      s.chan_b_in2        = b2;
      s.chan_a_compare    = PER_W'(cmp_a);
      s.chan_b_compare    = PER_W'(cmp_b);
      s.left_command_now  = CMD_W'(left_cmd);
      s.right_command_now = CMD_W'(right_cmd);
      s.last              = last_flag;
      return s;
    endfunction

    // Work out the results of one accepted request
    function void note_request(logic kind, logic signed [CMD_W-1:0] lreq,
                               logic signed [CMD_W-1:0] rreq);
      int  lim, l, r, lc, rc;
      bit  lflip, rflip, l1, l2, r1, r2;
      requests++;
      if (kind == KIND_STOP) begin
        stops++;
        {a1, a2, b1, b2} = 4'b0000;
        cmp_a = 0;
        cmp_b = 0;
        left_cmd = 0;
        right_cmd = 0;
        expected_results.push_back(snapshot(1'b1));
        return;
      end
      lim = (limit_reg == 0) ? 1 : int'(limit_reg);
      l = clamp(int'(lreq), lim);
      r = clamp(int'(rreq), lim);
      lflip = reverses(left_cmd, l);
      rflip = reverses(right_cmd, r);
      // Safe result: zero the reversing channel, hold everything else
      if (lflip || rflip) begin
        if (lflip) begin
          if (swap) cmp_b = 0;
          else cmp_a = 0;
        end
        if (rflip) begin
          if (swap) cmp_a = 0;
          else cmp_b = 0;
        end
        safe_seen++;
        expected_results.push_back(snapshot(1'b0));
      end
      side_levels(l, left_fwd, l1, l2);
      side_levels(r, right_fwd, r1, r2);
      lc = duty_count(l, lim);
      rc = duty_count(r, lim);
      if (swap) begin
        {a1, a2, b1, b2} = {r1, r2, l1, l2};
        cmp_a = rc;
        cmp_b = lc;
      end else begin
        {a1, a2, b1, b2} = {l1, l2, r1, r2};
        cmp_a = lc;
        cmp_b = rc;
      end
      left_cmd = l;
      right_cmd = r;
      expected_results.push_back(snapshot(1'b1));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("result %0d field %s: got %0d, want %0d",
                                  results_checked, name, got, want));
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(res_t got);
      res_t want;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  results_checked));
        results_checked++;
        return;
      end
      want = expected_results.pop_front();
      check_field("chan_a_in1", got.chan_a_in1, want.chan_a_in1);
      check_field("chan_a_in2", got.chan_a_in2, want.chan_a_in2);
      check_field("chan_b_in1", got.chan_b_in1, want.chan_b_in1);
      check_field("chan_b_in2", got.chan_b_in2, want.chan_b_in2);
      check_field("chan_a_compare", got.chan_a_compare, want.chan_a_compare);
      check_field("chan_b_compare", got.chan_b_compare, want.chan_b_compare);
      check_field("left_command_now", got.left_command_now, want.left_command_now);
      check_field("right_command_now", got.right_command_now, want.right_command_now);
      check_field("last", got.last, want.last);
      results_checked++;
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  dhb_in_if  in_ch();
  dhb_out_if out_ch();

  dual_hbridge_pwm_command_core #(
    .DEAD_TIME_CYCLES(DEAD_CYCLES)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  hbridge_scoreboard sb = new();

  bit   src_idle_en = 1'b1;
  bit   snk_idle_en = 1'b1;
  int   hold_ask    = 0;
  bit   hold_taken  = 1'b0;
  int   hold_left   = 0;
  int   cycle_count = 0;
  int   cfg_writes  = 0;
  int   settings    = 0;
  int   cur_lim     = 1000;
  int   prev_left   = 0;
  int   prev_right  = 0;
  res_t seen;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Abort a hung run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Check results and pace the result ready
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      seen.chan_a_in1        = out_ch.chan_a_in1;
      seen.chan_a_in2        = out_ch.chan_a_in2;
      seen.chan_b_in1        = out_ch.chan_b_in1;
      seen.chan_b_in2        = out_ch.chan_b_in2;
      seen.chan_a_compare    = out_ch.chan_a_compare;
      seen.chan_b_compare    = out_ch.chan_b_compare;
      seen.left_command_now  = out_ch.left_command_now;
      seen.right_command_now = out_ch.right_command_now;
      seen.last              = out_ch.last;
      sb.check_result(seen);
    end
    if (hold_ask > 0 && !hold_taken) begin
      hold_left  = hold_ask;
      hold_taken = 1'b1;
    end
    if (rst_n !== 1'b1) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (snk_idle_en) begin
      out_ch.ready <= ($urandom_range(0, 99) >= 33);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_request(input logic kind, input logic signed [CMD_W-1:0] lreq,
                              input logic signed [CMD_W-1:0] rreq);
    while (src_idle_en && $urandom_range(0, 99) < 33) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.left_request  <= lreq;
    in_ch.right_request <= rreq;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    sb.note_request(kind, lreq, rreq);
  endtask

  task automatic drive(input int l, input int r);
    send_request(KIND_DRIVE, CMD_W'(l), CMD_W'(r));
  endtask

  // Drop valid and wait until every expected result has come
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle and access cycle, then back to idle
  task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.write_reg(idx, data);
    cfg_writes++;
    @(posedge clk);
  endtask

  // Load all registers; upper bits carry junk the block must drop
  task automatic load_config(input int limit_word, input int period_word,
                             input bit lf, input bit rf, input bit sw);
    wait_drained();
    cfg_write(REG_COMMAND_LIMIT, ($urandom() & ~32'h7FFF) | (limit_word & 32'h7FFF));
    cfg_write(REG_PWM_PERIOD, ($urandom() & ~32'hFFFF) | (period_word & 32'hFFFF));
    cfg_write(REG_LEFT_FWD, ($urandom() & ~32'h1) | lf);
    cfg_write(REG_RIGHT_FWD, ($urandom() & ~32'h1) | rf);
    cfg_write(REG_SWAP_SIDES, ($urandom() & ~32'h1) | sw);
    cur_lim = ((limit_word & 32'h7FFF) == 0) ? 1 : (limit_word & 32'h7FFF);
    settings++;
  endtask

  function automatic int rand_request(int lim, int prev);
    case ($urandom_range(0, 11))
      0: return 0;
      1: return int'($signed(CMD_W'($urandom())));
      2: return 32767;
      3: return -32768;
      4: return lim;
      5: return -lim;
      6: return -prev;
      default: return int'($urandom_range(0, 2 * lim)) - lim;
    endcase
  endfunction

  function automatic int rand_limit_word();
    case ($urandom_range(0, 5))
      0: return 1;
      1: return 32767;
      2: return 0;
      3: return $urandom_range(1, 20);
      default: return $urandom_range(1, 32767);
    endcase
  endfunction

  function automatic int rand_period_word();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return 1;
      2: return 65535;
      3: return $urandom_range(1, 100);
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  initial begin
    int  limit_word, period_word, l, r;
    logic kind;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.kind          <= KIND_DRIVE;
    in_ch.left_request  <= '0;
    in_ch.right_request <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset settings, saturation, reversals on each side and both
    send_request(KIND_STOP, 16'sd0, 16'sd0);
    drive(0, 0);
    drive(32767, -32768);
    drive(-32768, 32767);
    drive(1, -1);
    drive(-1, 0);
    drive(0, 0);
    drive(500, -250);
    drive(-500, -250);
    drive(-500, 250);
    send_request(KIND_STOP, 16'sd1234, -16'sd1234);
    drive(-7, 7);
    drive(1001, -1001);

    // Directed: largest limit and period, inverted polarities, swapped sides
    load_config(32767, 65535, 1'b0, 1'b1, 1'b1);
    drive(32767, -32767);
    drive(-32768, 32767);
    drive(16384, 0);

    // Directed: zero limit acts as one, then zero period
    load_config(0, 7, 1'b1, 1'b0, 1'b0);
    drive(5, -5);
    drive(0, 3);
    load_config(10, 0, 1'b1, 1'b1, 1'b0);
    drive(10, -10);

    // Directed: swap changes between a drive and its reversal
    load_config(1000, 500, 1'b1, 1'b0, 1'b0);
    drive(200, 200);
    wait_drained();
    cfg_write(REG_SWAP_SIDES, 32'h1);
    drive(-200, 200);
    send_request(KIND_STOP, 16'sd0, 16'sd0);

    // Random phases, each under its own settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      limit_word  = rand_limit_word();
      period_word = rand_period_word();
      if (ph == 0) begin
        limit_word  = 1;
        period_word = 1;
      end else if (ph == 1) begin
        limit_word  = 32767;
        period_word = 65535;
      end
      load_config(limit_word, period_word, $urandom_range(0, 1), $urandom_range(0, 1),
                  $urandom_range(0, 1));
      src_idle_en = (ph != 3);
      snk_idle_en = (ph != 3);
      if (ph == 5) hold_ask = HOLD_CYCLES;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == 57 || $urandom_range(0, 199) == 0) wait_drained();
        kind = ($urandom_range(0, 99) < 12) ? KIND_STOP : KIND_DRIVE;
        l = rand_request(cur_lim, prev_left);
        r = rand_request(cur_lim, prev_right);
        if (kind == KIND_DRIVE) begin
          prev_left  = l;
          prev_right = r;
        end
        send_request(kind, CMD_W'(l), CMD_W'(r));
      end
    end

    // Drain, then give late or extra results time to show up
    wait_drained();
    repeat (DEAD_CYCLES + 2 * DRIVE_LAT + 20) @(posedge clk);
    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d expected results never arrived", sb.pending()));

    $display("Covered %0d requests (%0d stops) under %0d settings, %0d register writes",
             sb.requests, sb.stops, settings, cfg_writes);
    $display("Checked %0d results, %0d of them safe pre-reversal results, in %0d cycles",
             sb.results_checked, sb.safe_seen, cycle_count);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
